// ===== src/cpv_pkg.sv =====
package cpv_pkg;

  // Default depth of the interval buffer
  localparam int unsigned NumIntervalsDef = 3;

  // Stream payload widths
  localparam int unsigned InDataW  = 40;  // time_ms, pin_level, zero fill
  localparam int unsigned OutDataW = 56;  // ready_flag, timed_out, period_out, period_time

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] RegMinPeriod   = 3'd0;
  localparam logic [2:0] RegMaxPeriod   = 3'd1;
  localparam logic [2:0] RegMaxSpread   = 3'd2;
  localparam logic [2:0] RegTimeoutSpan = 3'd3;
  localparam logic [2:0] RegDebounce    = 3'd4;

  // Register reset values
  localparam logic [15:0] MinPeriodRst   = 16'd20;
  localparam logic [15:0] MaxPeriodRst   = 16'd3000;
  localparam logic [15:0] MaxSpreadRst   = 16'd10;
  localparam logic [15:0] TimeoutSpanRst = 16'd3000;
  localparam logic [7:0]  DebounceRst    = 8'd5;

  // Request kinds
  localparam logic KindPinEvent = 1'b0;
  localparam logic KindQuery    = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DEB    = 8'b0000_0010,
    ST_SPAN   = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_SPREAD = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_JUDGE  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

endpackage

// ===== src/ext_clock_period_validator_core.sv =====
// Channel      | Dir | Handshake              | Payload
// s_axis       | in  | tvalid/tready          | tuser: kind; tdata: time_ms, pin_level
// m_axis       | out | tvalid/tready          | tdata: ready_flag, timed_out, period_out,
//              |     |                        |        period_time
// apb          | in  | psel/penable/pready    | paddr, pwdata, prdata
//
// One request is in work at a time. A query, a bounced interrupt, a low level or a
// first pulse passes the debounce and finish steps; an interrupt that measures an
// interval adds the span step. The interval that fills the buffer adds a scan of one
// stored interval per cycle through the compare/accumulate unit and a spread check,
// then the reciprocal multiply and the judge step unless the spread is too wide. A
// result not yet taken holds the last step; reset is asynchronous, active low, no clearing pass.
module ext_clock_period_validator_core #(
  parameter int unsigned NUM_INTERVALS = cpv_pkg::NumIntervalsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [cpv_pkg::InDataW-1:0] s_axis_tdata,  // [31:0] time_ms, [32] pin_level
  input  logic                       s_axis_tuser,  // [0] kind
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [cpv_pkg::OutDataW-1:0] m_axis_tdata, // [0] ready_flag, [1] timed_out,
                                                     // [17:2] period_out, [49:18] period_time
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpv_pkg::AddrW-1:0]  paddr,
  input  logic [cpv_pkg::DataW-1:0]  pwdata,
  output logic [cpv_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int unsigned IdxW    = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;
  localparam int unsigned SumW    = 16 + IdxW;
  localparam int unsigned RecipSh = SumW + IdxW;
  localparam int unsigned RecipW  = SumW + 2;
  // ceil(2^RecipSh / NUM_INTERVALS): exact floor quotient for any SumW-bit sum
  localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << RecipSh) + 64'(NUM_INTERVALS) - 64'd1) / 64'(NUM_INTERVALS));

  // ---------------- configuration registers ----------------
  logic [15:0] min_period_q, max_period_q, max_spread_q, timeout_span_q;
  logic [7:0]  debounce_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q   <= cpv_pkg::MinPeriodRst;
      max_period_q   <= cpv_pkg::MaxPeriodRst;
      max_spread_q   <= cpv_pkg::MaxSpreadRst;
      timeout_span_q <= cpv_pkg::TimeoutSpanRst;
      debounce_q     <= cpv_pkg::DebounceRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cpv_pkg::RegMinPeriod:   min_period_q   <= pwdata[15:0];
        cpv_pkg::RegMaxPeriod:   max_period_q   <= pwdata[15:0];
        cpv_pkg::RegMaxSpread:   max_spread_q   <= pwdata[15:0];
        cpv_pkg::RegTimeoutSpan: timeout_span_q <= pwdata[15:0];
        cpv_pkg::RegDebounce:    debounce_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      cpv_pkg::RegMinPeriod:   prdata = {16'd0, min_period_q};
      cpv_pkg::RegMaxPeriod:   prdata = {16'd0, max_period_q};
      cpv_pkg::RegMaxSpread:   prdata = {16'd0, max_spread_q};
      cpv_pkg::RegTimeoutSpan: prdata = {16'd0, timeout_span_q};
      cpv_pkg::RegDebounce:    prdata = {24'd0, debounce_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  cpv_pkg::state_e state_q, state_d;

  logic             kind_q, kind_d;
  logic             level_q, level_d;
  logic [31:0]      now_q, now_d;
  logic [31:0]      last_pulse_q, last_pulse_d;
  logic [31:0]      last_act_q, last_act_d;
  logic [15:0]      val_period_q, val_period_d;
  logic [31:0]      val_stamp_q, val_stamp_d;
  logic             ready_q, ready_d;
  logic [IdxW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [15:0]      lo_q, lo_d, hi_q, hi_d;
  logic             out_valid_q, out_valid_d;
  logic [cpv_pkg::OutDataW-1:0] out_data_q, out_data_d;

  // interval buffer
  logic [15:0] store_q [NUM_INTERVALS];
  logic        store_we;
  logic [15:0] store_rd_q;

  // shared subtractor: debounce distance or pulse interval
  logic [31:0] sub_b, diff;
  logic        in_range;
  logic        fill_last;
  logic [15:0] scan_val;
  logic [SumW+RecipW-1:0] prod;
  logic [15:0] avg, avg_lo;
  logic [31:0] act_end;
  logic        timed_out;

  assign sub_b     = state_q[1] ? last_act_q : last_pulse_q;  // ST_DEB selects activity stamp
  assign diff      = now_q - sub_b;
  assign in_range  = (diff >= {16'd0, min_period_q}) && (diff <= {16'd0, max_period_q});
  assign fill_last = ({1'b0, fill_q} + (IdxW+1)'(1)) == (IdxW+1)'(NUM_INTERVALS);
  assign scan_val  = store_rd_q;

  // floor average by reciprocal multiply with the buffer depth
  assign prod = {{RecipW{1'b0}}, sum_q} * {{SumW{1'b0}}, Recip};

  // clamp of the average; quotient of 16-bit values fits 16 bits
  assign avg_lo = (sum_q < {{(SumW-16){1'b0}}, min_period_q}) ? min_period_q : sum_q[15:0];
  assign avg    = (avg_lo > max_period_q) ? max_period_q : avg_lo;

  // timeout status at the request time
  assign act_end   = last_act_q + {16'd0, timeout_span_q};
  assign timed_out = (last_act_q == 32'd0) || (now_q > act_end);

  assign store_we = (state_q == cpv_pkg::ST_SPAN) && in_range;

  // buffer write and registered read at the next scan index
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[fill_q] <= diff[15:0];
    end
    store_rd_q <= store_q[idx_d];
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    level_d      = level_q;
    now_d        = now_q;
    last_pulse_d = last_pulse_q;
    last_act_d   = last_act_q;
    val_period_d = val_period_q;
    val_stamp_d  = val_stamp_q;
    ready_d      = ready_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    sum_d        = sum_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;

    unique case (state_q)
      cpv_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = s_axis_tuser;
          now_d   = s_axis_tdata[31:0];
          level_d = s_axis_tdata[32];
          state_d = cpv_pkg::ST_DEB;
        end
      end
      cpv_pkg::ST_DEB: begin
        if (kind_q == cpv_pkg::KindQuery || diff < {24'd0, debounce_q}) begin
          state_d = cpv_pkg::ST_FINISH;
        end else begin
          last_act_d = now_q;
          if (!level_q) begin
            state_d = cpv_pkg::ST_FINISH;
          end else if (last_pulse_q == 32'd0) begin
            last_pulse_d = now_q;
            state_d      = cpv_pkg::ST_FINISH;
          end else begin
            state_d = cpv_pkg::ST_SPAN;
          end
        end
      end
      cpv_pkg::ST_SPAN: begin
        last_pulse_d = now_q;
        state_d      = cpv_pkg::ST_FINISH;
        if (!in_range) begin
          fill_d = '0;
        end else if (fill_last) begin
          idx_d   = '0;
          sum_d   = '0;
          lo_d    = 16'hFFFF;
          hi_d    = 16'd0;
          state_d = cpv_pkg::ST_SCAN;
        end else begin
          fill_d = fill_q + IdxW'(1);
        end
      end
      cpv_pkg::ST_SCAN: begin
        // one stored interval per cycle: sum, min, max
        sum_d = sum_q + {{(SumW-16){1'b0}}, scan_val};
        if (scan_val < lo_q) lo_d = scan_val;
        if (scan_val > hi_q) hi_d = scan_val;
        if (idx_q == IdxW'(NUM_INTERVALS - 1)) begin
          state_d = cpv_pkg::ST_SPREAD;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      cpv_pkg::ST_SPREAD: begin
        if ((hi_q - lo_q) <= max_spread_q) begin
          state_d = cpv_pkg::ST_DIV;
        end else begin
          fill_d  = '0;
          state_d = cpv_pkg::ST_FINISH;
        end
      end
      cpv_pkg::ST_DIV: begin
        // sum_q takes the floor average
        sum_d   = {{(SumW-16){1'b0}}, prod[RecipSh +: 16]};
        state_d = cpv_pkg::ST_JUDGE;
      end
      cpv_pkg::ST_JUDGE: begin
        if (avg != val_period_q) begin
          val_period_d = avg;
          val_stamp_d  = now_q;
          ready_d      = 1'b1;
        end
        fill_d  = '0;
        state_d = cpv_pkg::ST_FINISH;
      end
      cpv_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0,
                         timed_out ? 32'd0 : val_stamp_q,
                         timed_out ? 16'd0 : val_period_q,
                         timed_out, ready_q};
          if (kind_q == cpv_pkg::KindQuery) ready_d = 1'b0;
          state_d = cpv_pkg::ST_IDLE;
        end
      end
      default: state_d = cpv_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cpv_pkg::ST_IDLE;
      last_pulse_q <= '0;
      last_act_q   <= '0;
      val_period_q <= '0;
      val_stamp_q  <= '0;
      ready_q      <= 1'b0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_pulse_q <= last_pulse_d;
      last_act_q   <= last_act_d;
      val_period_q <= val_period_d;
      val_stamp_q  <= val_stamp_d;
      ready_q      <= ready_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    level_q    <= level_d;
    now_q      <= now_d;
    idx_q      <= idx_d;
    sum_q      <= sum_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == cpv_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/cpv_checker.sv =====
module cpv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cpv_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          pready
);

  // one request in work: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  // a result never appears the cycle after acceptance
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // timed-out status hides period and stamp
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[49:2] == 48'd0)
    else $error("period reported while timed out");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // register port never waits
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind ext_clock_period_validator_core cpv_checker u_cpv_checker (.*);
